### hdl/obb_overlap_separating_axis_macros.svh
// ---------------------------------------------------------------------------
// OBB overlap test assertion macros
// Shorthand for the concurrent checks used in the overlap test block.
// ---------------------------------------------------------------------------
`ifndef OBB_OVERLAP_SEPARATING_AXIS_MACROS_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OBSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/obsa_pkg.sv
// ---------------------------------------------------------------------------
// OBB overlap test package
// Sequencer states, accumulate operations and the per-axis microcode table.
// ---------------------------------------------------------------------------
package obsa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_DONE
  } state_t;

  // What the projection unit does with the registered product.
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_START,
    ACC_LHS,
    ACC_TLOAD,
    ACC_TADD,
    ACC_RADD
  } acc_op_t;

  typedef enum logic [2:0] {
    A_DX,
    A_DY,
    A_AX,
    A_AY,
    A_HALF
  } a_sel_t;

  typedef enum logic [1:0] {
    B_PX,
    B_PY,
    B_TMAG
  } b_sel_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc;
  } ctrl_t;

  typedef struct packed {
    acc_op_t    acc;
    a_sel_t     a_sel;
    b_sel_t     b_sel;
    logic [1:0] box_axis;
  } op_dec_t;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LAST = 4'd13;
  localparam logic [1:0] AXIS_LAST = 2'd3;
  localparam logic KIND_LOAD = 1'b0;

  // Fourteen products per candidate axis. The first two form the center
  // offset projection, then each of the four box axes takes three: the two
  // halves of its dot product with the candidate, and the half extent times
  // the magnitude of that dot product.
  function automatic op_dec_t op_decode(input logic [OP_W-1:0] op);
    op_dec_t d;
    d = '{ACC_NONE, A_DX, B_PX, 2'd0};
    case (op)
      4'd0:    d = '{ACC_START, A_DX,   B_PX,   2'd0};
      4'd1:    d = '{ACC_LHS,   A_DY,   B_PY,   2'd0};
      4'd2:    d = '{ACC_TLOAD, A_AX,   B_PX,   2'd0};
      4'd3:    d = '{ACC_TADD,  A_AY,   B_PY,   2'd0};
      4'd4:    d = '{ACC_RADD,  A_HALF, B_TMAG, 2'd0};
      4'd5:    d = '{ACC_TLOAD, A_AX,   B_PX,   2'd1};
      4'd6:    d = '{ACC_TADD,  A_AY,   B_PY,   2'd1};
      4'd7:    d = '{ACC_RADD,  A_HALF, B_TMAG, 2'd1};
      4'd8:    d = '{ACC_TLOAD, A_AX,   B_PX,   2'd2};
      4'd9:    d = '{ACC_TADD,  A_AY,   B_PY,   2'd2};
      4'd10:   d = '{ACC_RADD,  A_HALF, B_TMAG, 2'd2};
      4'd11:   d = '{ACC_TLOAD, A_AX,   B_PX,   2'd3};
      4'd12:   d = '{ACC_TADD,  A_AY,   B_PY,   2'd3};
      4'd13:   d = '{ACC_RADD,  A_HALF, B_TMAG, 2'd3};
      default: d = '{ACC_NONE,  A_DX,   B_PX,   2'd0};
    endcase
    return d;
  endfunction

endpackage

### hdl/obsa_proj_unit.sv
// ---------------------------------------------------------------------------
// OBB overlap projection unit
// Shared signed multiplier with the accumulators for one candidate axis.
// ---------------------------------------------------------------------------
module obsa_proj_unit #(
  parameter int AOP_W          = 25,
  parameter int BOP_W          = 33,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  obsa_pkg::ctrl_t         ctrl,
  input  logic signed [AOP_W-1:0] op_a,
  input  logic signed [BOP_W-1:0] op_b,
  output logic [BOP_W-2:0]        t_mag,
  output logic                    separated
);

  localparam int PROD_W = AOP_W + BOP_W;
  localparam int T_W    = PROD_W + 1;
  localparam int RHS_W  = PROD_W + 1;
  localparam int CMP_W  = T_W + AXIS_FRAC_BITS;

  logic signed [PROD_W-1:0] prod;
  logic signed [T_W-1:0]    t;
  logic signed [T_W-1:0]    t_sum;
  logic [T_W-1:0]           t_abs;
  logic [T_W-1:0]           lhs;
  logic [RHS_W-1:0]         rhs;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= op_a * op_b;
    end
  end

  assign t_sum = t + T_W'(prod);
  assign t_abs = t[T_W-1] ? T_W'(-t) : T_W'(t);
  // Only read while t holds an axis dot product, which fits these bits.
  assign t_mag = t_abs[BOP_W-2:0];

  always_ff @(posedge clk) begin
    case (ctrl.acc)
      obsa_pkg::ACC_START: begin
        t   <= T_W'(prod);
        rhs <= '0;
      end
      obsa_pkg::ACC_LHS: begin
        lhs <= t_sum[T_W-1] ? T_W'(-t_sum) : T_W'(t_sum);
      end
      obsa_pkg::ACC_TLOAD: begin
        t <= T_W'(prod);
      end
      obsa_pkg::ACC_TADD: begin
        t <= t_sum;
      end
      obsa_pkg::ACC_RADD: begin
        rhs <= rhs + RHS_W'(prod);
      end
      default: begin
      end
    endcase
  end

  // The offset projection carries one axis scale fewer than the half terms.
  assign separated = ({lhs, {AXIS_FRAC_BITS{1'b0}}} > CMP_W'(rhs));

endmodule

### hdl/obb_overlap_separating_axis.sv
// ---------------------------------------------------------------------------
// OBB overlap separating-axis test
// Two-dimensional oriented box overlap against a stored reference box.
// ---------------------------------------------------------------------------
// A load word (kind 0) stores the reference box and returns no result. A
// test word (kind 1) returns one hit word: 1 when the test box overlaps the
// reference and both boxes are active. When either box is inactive the
// sequencer goes straight to the done state with a hit word of 0. Otherwise
// the four candidate axes (reference u, reference v, test u, test v) are
// checked in turn on one shared signed multiplier. Each axis needs fourteen
// products, every product passes through a multiply state and then an
// accumulate state, and the axis ends in a compare state; a test stops at
// the first axis that separates. The block takes no new word while a test is
// in progress, but the hit word sits in an output register so the next word
// can be accepted while it waits. The offset projection is compared strictly
// against the sum of the four projected half extents with exact wide
// arithmetic, so equal values do not separate.
// ---------------------------------------------------------------------------
`include "obb_overlap_separating_axis_macros.svh"

module obb_overlap_separating_axis #(
  parameter int POS_WIDTH      = 24,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic                        active,
  input  logic signed [POS_WIDTH-1:0] center_x,
  input  logic signed [POS_WIDTH-1:0] center_y,
  input  logic signed [AXIS_FRAC_BITS+1:0] axis_u_x,
  input  logic signed [AXIS_FRAC_BITS+1:0] axis_u_y,
  input  logic signed [AXIS_FRAC_BITS+1:0] axis_v_x,
  input  logic signed [AXIS_FRAC_BITS+1:0] axis_v_y,
  input  logic [POS_WIDTH-2:0]        half_u,
  input  logic [POS_WIDTH-2:0]        half_v,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit
);

  localparam int AXIS_W = AXIS_FRAC_BITS + 2;
  localparam int DIFF_W = POS_WIDTH + 1;
  localparam int HALF_W = POS_WIDTH - 1;
  // Operand A carries the center offset, an axis component or a half extent.
  localparam int AOP_W  = (DIFF_W > AXIS_W) ? DIFF_W : AXIS_W;
  // Operand B carries a candidate axis component or the magnitude of a dot
  // product of two axes.
  localparam int BOP_W  = 2 * AXIS_W + 1;

  obsa_pkg::state_t state, state_next;

  logic [1:0]               axis, axis_next;
  logic [obsa_pkg::OP_W-1:0] op, op_next;
  logic                     res, res_next;
  logic                     out_load;
  logic                     in_accept;

  // Stored reference box.
  logic                     ref_active;
  logic signed [POS_WIDTH-1:0] ref_cx, ref_cy;
  logic signed [AXIS_W-1:0] ref_ux, ref_uy, ref_vx, ref_vy;
  logic [HALF_W-1:0]        ref_hu, ref_hv;

  // Box under test, with its center already taken relative to the reference.
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [AXIS_W-1:0] tst_ux, tst_uy, tst_vx, tst_vy;
  logic [HALF_W-1:0]        tst_hu, tst_hv;

  obsa_pkg::op_dec_t        dec;
  obsa_pkg::ctrl_t          ctrl;
  logic signed [AXIS_W-1:0] px, py, ax, ay;
  logic [HALF_W-1:0]        half;
  logic signed [AOP_W-1:0]  op_a;
  logic signed [BOP_W-1:0]  op_b;
  logic [BOP_W-2:0]         t_mag;
  logic                     separated;

  assign in_stall  = (state != obsa_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // The candidate axis is chosen by the axis counter, the box axis being
  // projected by the microcode step.
  always_comb begin
    case (axis)
      2'd0:    begin px = ref_ux; py = ref_uy; end
      2'd1:    begin px = ref_vx; py = ref_vy; end
      2'd2:    begin px = tst_ux; py = tst_uy; end
      default: begin px = tst_vx; py = tst_vy; end
    endcase
  end

  assign dec = obsa_pkg::op_decode(op);

  always_comb begin
    case (dec.box_axis)
      2'd0:    begin ax = ref_ux; ay = ref_uy; half = ref_hu; end
      2'd1:    begin ax = ref_vx; ay = ref_vy; half = ref_hv; end
      2'd2:    begin ax = tst_ux; ay = tst_uy; half = tst_hu; end
      default: begin ax = tst_vx; ay = tst_vy; half = tst_hv; end
    endcase
  end

  always_comb begin
    case (dec.a_sel)
      obsa_pkg::A_DX:   op_a = AOP_W'(dx);
      obsa_pkg::A_DY:   op_a = AOP_W'(dy);
      obsa_pkg::A_AX:   op_a = AOP_W'(ax);
      obsa_pkg::A_AY:   op_a = AOP_W'(ay);
      obsa_pkg::A_HALF: op_a = AOP_W'({1'b0, half});
      default:          op_a = '0;
    endcase
    case (dec.b_sel)
      obsa_pkg::B_PX:   op_b = BOP_W'(px);
      obsa_pkg::B_PY:   op_b = BOP_W'(py);
      obsa_pkg::B_TMAG: op_b = {1'b0, t_mag};
      default:          op_b = '0;
    endcase
  end

  assign ctrl.mul_en = (state == obsa_pkg::ST_MUL);
  assign ctrl.acc    = (state == obsa_pkg::ST_ACC) ? dec.acc : obsa_pkg::ACC_NONE;

  obsa_proj_unit #(
    .AOP_W          (AOP_W),
    .BOP_W          (BOP_W),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_proj (
    .clk       (clk),
    .ctrl      (ctrl),
    .op_a      (op_a),
    .op_b      (op_b),
    .t_mag     (t_mag),
    .separated (separated)
  );

  // Sequencer: multiply and accumulate alternate through the fourteen steps
  // of an axis, then the compare decides whether to stop or move on.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    op_next    = op;
    res_next   = res;
    out_load   = 1'b0;
    case (state)
      obsa_pkg::ST_IDLE: begin
        if (in_accept && (kind != obsa_pkg::KIND_LOAD)) begin
          axis_next = '0;
          op_next   = '0;
          res_next  = 1'b0;
          if (ref_active && active) begin
            state_next = obsa_pkg::ST_MUL;
          end else begin
            state_next = obsa_pkg::ST_DONE;
          end
        end
      end
      obsa_pkg::ST_MUL: begin
        state_next = obsa_pkg::ST_ACC;
      end
      obsa_pkg::ST_ACC: begin
        if (op == obsa_pkg::OP_LAST) begin
          state_next = obsa_pkg::ST_CMP;
        end else begin
          op_next    = op + obsa_pkg::OP_W'(1);
          state_next = obsa_pkg::ST_MUL;
        end
      end
      obsa_pkg::ST_CMP: begin
        if (separated) begin
          res_next   = 1'b0;
          state_next = obsa_pkg::ST_DONE;
        end else if (axis == obsa_pkg::AXIS_LAST) begin
          res_next   = 1'b1;
          state_next = obsa_pkg::ST_DONE;
        end else begin
          axis_next  = axis + 2'd1;
          op_next    = '0;
          state_next = obsa_pkg::ST_MUL;
        end
      end
      obsa_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = obsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = obsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= obsa_pkg::ST_IDLE;
      ref_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept && (kind == obsa_pkg::KIND_LOAD)) begin
        ref_active <= active;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    axis <= axis_next;
    op   <= op_next;
    res  <= res_next;
    if (out_load) begin
      hit <= res;
    end
    if (in_accept) begin
      if (kind == obsa_pkg::KIND_LOAD) begin
        ref_cx <= center_x;
        ref_cy <= center_y;
        ref_ux <= axis_u_x;
        ref_uy <= axis_u_y;
        ref_vx <= axis_v_x;
        ref_vy <= axis_v_y;
        ref_hu <= half_u;
        ref_hv <= half_v;
      end else begin
        dx     <= DIFF_W'(center_x) - DIFF_W'(ref_cx);
        dy     <= DIFF_W'(center_y) - DIFF_W'(ref_cy);
        tst_ux <= axis_u_x;
        tst_uy <= axis_u_y;
        tst_vx <= axis_v_x;
        tst_vy <= axis_v_y;
        tst_hu <= half_u;
        tst_hv <= half_v;
      end
    end
  end

  // The compare is reached only after the last microcode step of an axis.
  `OBSA_ASSERT_SAME(a_cmp_after_last_op, clk, rst, state == obsa_pkg::ST_CMP, op == obsa_pkg::OP_LAST, "compare reached before the last step of the axis")
  // A hit can only come out of a full pass over all four axes.
  `OBSA_ASSERT_SAME(a_hit_needs_all_axes, clk, rst, (state == obsa_pkg::ST_DONE) && res, (axis == obsa_pkg::AXIS_LAST) && ref_active, "hit reported without checking every axis")
  // A new result word only appears out of the done state.
  `OBSA_ASSERT_SAME(a_out_from_done, clk, rst, $rose(out_valid), $past(state) == obsa_pkg::ST_DONE, "result word raised outside the done state")
  // A load word starts no computation.
  `OBSA_ASSERT_NEXT(a_load_no_work, clk, rst, in_accept && (kind == obsa_pkg::KIND_LOAD), state == obsa_pkg::ST_IDLE, "load word started a test sequence")

endmodule
